@@ sv/salsa_hash_pkg.sv @@
`timescale 1ns / 1ps

package salsa_hash_pkg;

    localparam int WORDS       = 16;
    localparam int WORD_W      = 32;
    localparam int BLOCK_W     = WORDS * WORD_W;
    localparam int IDX_W       = 4;
    localparam int FILL_W      = 6;
    localparam int STEP_W      = 5;
    localparam int ROUND_W     = 4;
    localparam int ROT_W       = 5;

    localparam logic [IDX_W-1:0]   LAST_IDX    = 4'd15;
    localparam logic [FILL_W-1:0]  LAST_FILL   = 6'd63;
    localparam logic [STEP_W-1:0]  LAST_STEP   = 5'd31;
    localparam logic [ROUND_W-1:0] FIRST_ROUND = 4'd10;
    localparam logic [ROUND_W-1:0] LAST_ROUND  = 4'd1;

    localparam logic REQ_ABSORB = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    localparam logic VARIANT_SALSA10 = 1'b0;
    localparam logic VARIANT_SALSA20 = 1'b1;

    typedef enum logic [1:0] {
        MIX_ADD,
        MIX_OR,
        MIX_XOR
    } mix_op_t;

    typedef struct packed {
        mix_op_t              pre_op;
        logic [ROT_W-1:0]     rot;
        logic                 xor_k;
        logic [ROUND_W-1:0]   round;
        mix_op_t              post_op;
    } mix_ctrl_t;

    typedef struct packed {
        logic [IDX_W-1:0] d;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
    } step_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAD,
        ST_COPY,
        ST_RD_AB,
        ST_RD_D,
        ST_WR_D,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_OUT_RD,
        ST_OUT_WAIT
    } state_t;

    function automatic step_idx_t step_index(input logic [STEP_W-1:0] step);
        step_idx_t s;
        unique case (step)
            5'd0:  s = '{4'd4,  4'd0,  4'd12};
            5'd1:  s = '{4'd8,  4'd4,  4'd0};
            5'd2:  s = '{4'd12, 4'd8,  4'd4};
            5'd3:  s = '{4'd0,  4'd12, 4'd8};
            5'd4:  s = '{4'd9,  4'd5,  4'd1};
            5'd5:  s = '{4'd13, 4'd9,  4'd5};
            5'd6:  s = '{4'd1,  4'd13, 4'd9};
            5'd7:  s = '{4'd5,  4'd1,  4'd13};
            5'd8:  s = '{4'd14, 4'd10, 4'd6};
            5'd9:  s = '{4'd2,  4'd14, 4'd10};
            5'd10: s = '{4'd6,  4'd2,  4'd14};
            5'd11: s = '{4'd10, 4'd6,  4'd2};
            5'd12: s = '{4'd3,  4'd15, 4'd11};
            5'd13: s = '{4'd7,  4'd3,  4'd15};
            5'd14: s = '{4'd11, 4'd7,  4'd3};
            5'd15: s = '{4'd15, 4'd11, 4'd7};
            5'd16: s = '{4'd1,  4'd0,  4'd3};
            5'd17: s = '{4'd2,  4'd1,  4'd0};
            5'd18: s = '{4'd3,  4'd2,  4'd1};
            5'd19: s = '{4'd0,  4'd3,  4'd2};
            5'd20: s = '{4'd6,  4'd5,  4'd4};
            5'd21: s = '{4'd7,  4'd6,  4'd5};
            5'd22: s = '{4'd4,  4'd7,  4'd6};
            5'd23: s = '{4'd5,  4'd4,  4'd7};
            5'd24: s = '{4'd11, 4'd10, 4'd9};
            5'd25: s = '{4'd8,  4'd11, 4'd10};
            5'd26: s = '{4'd9,  4'd8,  4'd11};
            5'd27: s = '{4'd10, 4'd9,  4'd8};
            5'd28: s = '{4'd12, 4'd15, 4'd14};
            5'd29: s = '{4'd13, 4'd12, 4'd15};
            5'd30: s = '{4'd14, 4'd13, 4'd12};
            5'd31: s = '{4'd15, 4'd14, 4'd13};
            default: s = '0;
        endcase
        return s;
    endfunction

    // pre op, rotation, round-counter xor, post op
    function automatic mix_ctrl_t step_ctrl(input logic variant,
                                            input logic [STEP_W-1:0] step,
                                            input logic [ROUND_W-1:0] round);
        mix_ctrl_t c;
        c.round = round;
        c.xor_k = 1'b0;
        if (variant == VARIANT_SALSA20) begin
            c.pre_op  = MIX_ADD;
            c.post_op = MIX_XOR;
            unique case (step[1:0])
                2'd0:    c.rot = 5'd7;
                2'd1:    c.rot = 5'd9;
                2'd2:    c.rot = 5'd13;
                2'd3:    c.rot = 5'd18;
                default: c.rot = 5'd7;
            endcase
        end else begin
            unique case (step)
                5'd0:  begin c.pre_op = MIX_ADD; c.rot = 5'd6;  c.post_op = MIX_XOR; end
                5'd1:  begin c.pre_op = MIX_ADD; c.rot = 5'd17; c.post_op = MIX_XOR; end
                5'd2:  begin c.pre_op = MIX_OR;  c.rot = 5'd16; c.post_op = MIX_ADD; end
                5'd3:  begin c.pre_op = MIX_XOR; c.rot = 5'd5;  c.post_op = MIX_ADD; end
                5'd4:  begin c.pre_op = MIX_OR;  c.rot = 5'd8;  c.post_op = MIX_ADD; end
                5'd5:  begin c.pre_op = MIX_OR;  c.rot = 5'd7;  c.post_op = MIX_ADD; end
                5'd6:  begin c.pre_op = MIX_ADD; c.rot = 5'd17; c.post_op = MIX_XOR; end
                5'd7:  begin c.pre_op = MIX_XOR; c.rot = 5'd12; c.post_op = MIX_ADD; end
                5'd8:  begin c.pre_op = MIX_ADD; c.rot = 5'd7;  c.post_op = MIX_XOR; end
                5'd9:  begin c.pre_op = MIX_XOR; c.rot = 5'd15; c.post_op = MIX_ADD; end
                5'd10: begin c.pre_op = MIX_ADD; c.rot = 5'd13; c.post_op = MIX_XOR; end
                5'd11: begin c.pre_op = MIX_ADD; c.rot = 5'd15; c.post_op = MIX_XOR; end
                5'd12: begin c.pre_op = MIX_OR;  c.rot = 5'd20; c.post_op = MIX_ADD; end
                5'd13: begin c.pre_op = MIX_ADD; c.rot = 5'd16; c.post_op = MIX_XOR; end
                5'd14: begin c.pre_op = MIX_XOR; c.rot = 5'd7;  c.post_op = MIX_ADD; end
                5'd15: begin c.pre_op = MIX_XOR; c.rot = 5'd8;  c.post_op = MIX_ADD; end
                5'd16: begin
                    c.pre_op = MIX_OR;  c.rot = 5'd8;  c.post_op = MIX_ADD; c.xor_k = 1'b1;
                end
                5'd17: begin c.pre_op = MIX_ADD; c.rot = 5'd14; c.post_op = MIX_XOR; end
                5'd18: begin c.pre_op = MIX_ADD; c.rot = 5'd6;  c.post_op = MIX_XOR; end
                5'd19: begin c.pre_op = MIX_XOR; c.rot = 5'd18; c.post_op = MIX_ADD; end
                5'd20: begin c.pre_op = MIX_XOR; c.rot = 5'd8;  c.post_op = MIX_ADD; end
                5'd21: begin c.pre_op = MIX_XOR; c.rot = 5'd12; c.post_op = MIX_ADD; end
                5'd22: begin c.pre_op = MIX_OR;  c.rot = 5'd13; c.post_op = MIX_ADD; end
                5'd23: begin c.pre_op = MIX_ADD; c.rot = 5'd15; c.post_op = MIX_XOR; end
                5'd24: begin c.pre_op = MIX_ADD; c.rot = 5'd18; c.post_op = MIX_XOR; end
                5'd25: begin c.pre_op = MIX_XOR; c.rot = 5'd11; c.post_op = MIX_ADD; end
                5'd26: begin c.pre_op = MIX_ADD; c.rot = 5'd8;  c.post_op = MIX_XOR; end
                5'd27: begin c.pre_op = MIX_OR;  c.rot = 5'd6;  c.post_op = MIX_ADD; end
                5'd28: begin c.pre_op = MIX_XOR; c.rot = 5'd17; c.post_op = MIX_ADD; end
                5'd29: begin c.pre_op = MIX_ADD; c.rot = 5'd15; c.post_op = MIX_XOR; end
                5'd30: begin c.pre_op = MIX_OR;  c.rot = 5'd9;  c.post_op = MIX_ADD; end
                5'd31: begin c.pre_op = MIX_XOR; c.rot = 5'd7;  c.post_op = MIX_ADD; end
                default: begin c.pre_op = MIX_ADD; c.rot = 5'd7; c.post_op = MIX_XOR; end
            endcase
        end
        return c;
    endfunction

endpackage

@@ sv/salsa_core_block_hash_core.sv @@
`timescale 1ns / 1ps
// channel | ports                                              | direction
// input   | s_valid s_ready s_req_type s_data_byte             | in
// result  | m_valid m_ready m_digest_word m_word_index m_last_word | out
// config  | cfg_wr_en cfg_wr_data                              | in
//
// An absorb beat shifts in one byte; the beat that fills a block then copies its
// 16 words to RAM (first block only), runs 320 word updates in the shared mixer
// (RD_AB, RD_D, WR_D each) and the feed-forward add (ADD_RD, ADD_WR per word).
// Finish zero-pads each missing byte, then emits each word via OUT_RD and
// OUT_WAIT, held on a result stall. s_ready is low while a block or the digest
// is busy. Reset is synchronous, active low, zeroes m_digest_word, not the RAM.

module salsa_core_block_hash_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [3:0]  m_word_index,
    output logic        m_last_word
);

    import salsa_hash_pkg::*;

    state_t               state_reg, state_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic                 first_done_reg, first_done_next;
    logic                 finish_reg, finish_next;
    logic                 variant_reg;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [ROUND_W-1:0]   round_reg, round_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [BLOCK_W-1:0]   block_reg, block_next;
    logic [WORD_W-1:0]    t_reg, t_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic                 ram_re0, ram_re1;
    logic [IDX_W-1:0]     ram_raddr0, ram_raddr1;
    logic [WORD_W-1:0]    ram_rdata0, ram_rdata1;
    logic [WORD_W-1:0]    chain_rd0;

    step_idx_t            sidx;
    mix_ctrl_t            mctrl;
    logic [WORD_W-1:0]    mix_post_t;
    logic [WORD_W-1:0]    mix_pre_result, mix_post_result;
    logic [WORD_W-1:0]    blk_top;
    state_t               blk_start;

    assign sidx      = step_index(step_reg);
    assign blk_top   = block_reg[BLOCK_W-1 -: WORD_W];
    assign chain_rd0 = first_done_reg ? ram_rdata0 : '0;
    assign blk_start = first_done_reg ? ST_RD_AB : ST_COPY;

    salsa_hash_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_chain (
        .aclk     (aclk),
        .wr_en    (ram_we),
        .wr_addr  (ram_waddr),
        .wr_data  (mix_post_result),
        .rd0_en   (ram_re0),
        .rd0_addr (ram_raddr0),
        .rd0_data (ram_rdata0),
        .rd1_en   (ram_re1),
        .rd1_addr (ram_raddr1),
        .rd1_data (ram_rdata1)
    );

    salsa_hash_mix u_mix (
        .ctrl        (mctrl),
        .pre_a       (chain_rd0),
        .pre_b       (ram_rdata1),
        .post_x      (chain_rd0),
        .post_t      (mix_post_t),
        .pre_result  (mix_pre_result),
        .post_result (mix_post_result)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_req_type == REQ_ABSORB) begin
                        if (fill_reg == LAST_FILL) begin
                            state_next = blk_start;
                        end
                    end else if (fill_reg != '0) begin
                        state_next = ST_PAD;
                    end else begin
                        state_next = ST_OUT_RD;
                    end
                end
            end
            ST_PAD: begin
                if (fill_reg == LAST_FILL) begin
                    state_next = blk_start;
                end
            end
            ST_COPY: begin
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_RD_AB;
                end
            end
            ST_RD_AB: state_next = ST_RD_D;
            ST_RD_D:  state_next = ST_WR_D;
            ST_WR_D: begin
                if (step_reg == LAST_STEP && round_reg == LAST_ROUND) begin
                    state_next = ST_ADD_RD;
                end else begin
                    state_next = ST_RD_AB;
                end
            end
            ST_ADD_RD: state_next = ST_ADD_WR;
            ST_ADD_WR: begin
                if (idx_reg == LAST_IDX) begin
                    state_next = finish_reg ? ST_OUT_RD : ST_IDLE;
                end else begin
                    state_next = ST_ADD_RD;
                end
            end
            ST_OUT_RD: state_next = ST_OUT_WAIT;
            ST_OUT_WAIT: begin
                if (m_ready) begin
                    state_next = (idx_reg == LAST_IDX) ? ST_IDLE : ST_OUT_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        fill_next       = fill_reg;
        first_done_next = first_done_reg;
        finish_next     = finish_reg;
        step_next       = step_reg;
        round_next      = round_reg;
        idx_next        = idx_reg;
        block_next      = block_reg;
        t_next          = t_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_re0         = 1'b0;
        ram_re1         = 1'b0;
        ram_raddr0      = idx_reg;
        ram_raddr1      = sidx.b;
        mctrl           = step_ctrl(variant_reg, step_reg, round_reg);
        mix_post_t      = t_reg;
        s_ready         = 1'b0;
        m_valid         = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                idx_next   = '0;
                step_next  = '0;
                round_next = FIRST_ROUND;
                if (s_valid) begin
                    if (s_req_type == REQ_ABSORB) begin
                        block_next  = {block_reg[BLOCK_W-9:0], s_data_byte};
                        fill_next   = fill_reg + 1'b1;
                        finish_next = 1'b0;
                    end else begin
                        finish_next = 1'b1;
                    end
                end
            end
            ST_PAD: begin
                block_next = {block_reg[BLOCK_W-9:0], 8'h00};
                fill_next  = fill_reg + 1'b1;
            end
            ST_COPY: begin
                ram_we          = 1'b1;
                mctrl.post_op   = MIX_OR;
                mix_post_t      = blk_top;
                block_next      = {block_reg[BLOCK_W-WORD_W-1:0], blk_top};
                idx_next        = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX) begin
                    first_done_next = 1'b1;
                end
            end
            ST_RD_AB: begin
                ram_re0    = 1'b1;
                ram_re1    = 1'b1;
                ram_raddr0 = sidx.a;
            end
            ST_RD_D: begin
                t_next     = mix_pre_result;
                ram_re0    = 1'b1;
                ram_raddr0 = sidx.d;
            end
            ST_WR_D: begin
                ram_we    = 1'b1;
                ram_waddr = sidx.d;
                step_next = step_reg + 1'b1;
                idx_next  = '0;
                if (step_reg == LAST_STEP) begin
                    round_next = round_reg - 1'b1;
                end
            end
            ST_ADD_RD: begin
                ram_re0 = 1'b1;
            end
            ST_ADD_WR: begin
                ram_we        = 1'b1;
                mctrl.post_op = MIX_ADD;
                mix_post_t    = blk_top;
                block_next    = {block_reg[BLOCK_W-WORD_W-1:0], blk_top};
                idx_next      = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX) begin
                    block_next = '0;
                end
            end
            ST_OUT_RD: begin
                ram_re0 = 1'b1;
            end
            ST_OUT_WAIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == LAST_IDX) begin
                        first_done_next = 1'b0;
                        finish_next     = 1'b0;
                        fill_next       = '0;
                        block_next      = '0;
                    end
                end
            end
            default: begin
                idx_next = '0;
            end
        endcase
    end

    // the copy pass writes the block word: chain_rd0 is zero before the first block
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            first_done_reg <= 1'b0;
            finish_reg     <= 1'b0;
            variant_reg    <= VARIANT_SALSA20;
            step_reg       <= '0;
            round_reg      <= FIRST_ROUND;
            idx_reg        <= '0;
            block_reg      <= '0;
        end else begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            first_done_reg <= first_done_next;
            finish_reg     <= finish_next;
            step_reg       <= step_next;
            round_reg      <= round_next;
            idx_reg        <= idx_next;
            block_reg      <= block_next;
            if (cfg_wr_en) begin
                variant_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        t_reg <= t_next;
    end

    assign m_digest_word = chain_rd0;
    assign m_word_index  = idx_reg;
    assign m_last_word   = (idx_reg == LAST_IDX);

endmodule

@@ sv/salsa_hash_ram.sv @@
`timescale 1ns / 1ps

module salsa_hash_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd0_en,
    input  logic [$clog2(DEPTH)-1:0] rd0_addr,
    output logic [WIDTH-1:0]         rd0_data,
    input  logic                     rd1_en,
    input  logic [$clog2(DEPTH)-1:0] rd1_addr,
    output logic [WIDTH-1:0]         rd1_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd0_reg;
    logic [WIDTH-1:0] rd1_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd0_en) begin
            rd0_reg <= mem_reg[rd0_addr];
        end
        if (rd1_en) begin
            rd1_reg <= mem_reg[rd1_addr];
        end
    end

    assign rd0_data = rd0_reg;
    assign rd1_data = rd1_reg;

endmodule

@@ sv/salsa_hash_mix.sv @@
`timescale 1ns / 1ps

module salsa_hash_mix (
    input  salsa_hash_pkg::mix_ctrl_t           ctrl,
    input  logic [salsa_hash_pkg::WORD_W-1:0]   pre_a,
    input  logic [salsa_hash_pkg::WORD_W-1:0]   pre_b,
    input  logic [salsa_hash_pkg::WORD_W-1:0]   post_x,
    input  logic [salsa_hash_pkg::WORD_W-1:0]   post_t,
    output logic [salsa_hash_pkg::WORD_W-1:0]   pre_result,
    output logic [salsa_hash_pkg::WORD_W-1:0]   post_result
);

    import salsa_hash_pkg::*;

    logic [WORD_W-1:0]   comb_word;
    logic [2*WORD_W-1:0] rot_dbl;

    always_comb begin
        unique case (ctrl.pre_op)
            MIX_ADD: comb_word = pre_a + pre_b;
            MIX_OR:  comb_word = pre_a | pre_b;
            MIX_XOR: comb_word = pre_a ^ pre_b;
            default: comb_word = pre_a + pre_b;
        endcase
        rot_dbl    = {comb_word, comb_word} << ctrl.rot;
        pre_result = rot_dbl[2*WORD_W-1:WORD_W];
        if (ctrl.xor_k) begin
            pre_result = pre_result ^ {{(WORD_W-ROUND_W){1'b0}}, ctrl.round};
        end
    end

    always_comb begin
        unique case (ctrl.post_op)
            MIX_ADD: post_result = post_x + post_t;
            MIX_OR:  post_result = post_x | post_t;
            MIX_XOR: post_result = post_x ^ post_t;
            default: post_result = post_x + post_t;
        endcase
    end

endmodule
